// ----- hdl/mtbp_pkg.sv -----
// Shared types, character codes and arithmetic helpers for the telemetry byte parser.
// Used by mtbp_decode, mtbp_core and mfd_telemetry_byte_parser; no dependencies.
package mtbp_pkg;

  localparam logic [7:0] CharD     = 8'h44;
  localparam logic [7:0] CharH     = 8'h48;
  localparam logic [7:0] CharA     = 8'h41;
  localparam logic [7:0] CharStar  = 8'h2A;
  localparam logic [7:0] CharNl    = 8'h0A;
  localparam logic [7:0] CharX     = 8'h58;
  localparam logic [7:0] CharHash  = 8'h23;
  localparam logic [7:0] CharAt    = 8'h40;
  localparam logic [7:0] CharN     = 8'h4E;
  localparam logic [7:0] CharE     = 8'h45;
  localparam logic [7:0] CharS     = 8'h53;
  localparam logic [7:0] CharW     = 8'h57;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] AsciiZero = 8'd48;

  localparam logic [15:0] TestDist = 16'd1000;
  localparam logic [15:0] TestAlt  = 16'd1000;
  localparam logic [15:0] AzNorth  = 16'd0;
  localparam logic [15:0] AzEast   = 16'd90;
  localparam logic [15:0] AzSouth  = 16'd180;
  localparam logic [15:0] AzWest   = 16'd270;

  localparam logic [7:0] RunSumReset = 8'd255;
  localparam logic [7:0] RcvSumReset = 8'd125;

  // Field selector codes
  localparam logic [2:0] FsIdle = 3'd0;
  localparam logic [2:0] FsDist = 3'd1;
  localparam logic [2:0] FsAlt  = 3'd2;
  localparam logic [2:0] FsAz   = 3'd3;
  localparam logic [2:0] FsSum  = 3'd4;

  typedef enum logic [3:0] {
    ChDist,
    ChAlt,
    ChAz,
    ChStar,
    ChNewline,
    ChHome,
    ChClear,
    ChNorth,
    ChEast,
    ChSouth,
    ChWest,
    ChOther
  } char_class_e;

  typedef struct packed {
    logic [15:0] distance;
    logic [15:0] azimuth;
    logic [15:0] altitude;
    logic        fix;
    logic        home;
    logic        test;
  } result_t;

  // acc * 10 + ch - '0', wrapping at 16 bits
  function automatic logic [15:0] times_ten_add16(input logic [15:0] acc,
                                                  input logic [7:0] ch);
    return (acc << 3) + (acc << 1) + {8'd0, ch} - {8'd0, AsciiZero};
  endfunction

  // acc * 10 + ch - '0', wrapping at 8 bits
  function automatic logic [7:0] times_ten_add8(input logic [7:0] acc,
                                                input logic [7:0] ch);
    return (acc << 3) + (acc << 1) + ch - AsciiZero;
  endfunction

endpackage

// ----- hdl/mtbp_decode.sv -----
// Character classifier: maps one received byte to its parser action class.
// Depends on mtbp_pkg.
module mtbp_decode (
  input  logic [7:0]           rx_byte_i,
  output mtbp_pkg::char_class_e char_class_o
);
  import mtbp_pkg::*;

  always_comb begin
    case (rx_byte_i)
      CharD:          char_class_o = ChDist;
      CharH:          char_class_o = ChAlt;
      CharA:          char_class_o = ChAz;
      CharStar:       char_class_o = ChStar;
      CharNl:         char_class_o = ChNewline;
      CharX:          char_class_o = ChHome;
      CharHash, CharAt: char_class_o = ChClear;
      CharN:          char_class_o = ChNorth;
      CharE:          char_class_o = ChEast;
      CharS:          char_class_o = ChSouth;
      CharW:          char_class_o = ChWest;
      default:        char_class_o = ChOther;
    endcase
  end

endmodule

// ----- hdl/mtbp_core.sv -----
// Parser state registers and per-byte update; presents the post-update result.
// Depends on mtbp_pkg and mtbp_decode.
module mtbp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [7:0]        rx_byte_i,
  output mtbp_pkg::result_t result_o
);
  import mtbp_pkg::*;

  char_class_e cls;

  logic [2:0]  field_q, field_d;
  logic [15:0] dist_q, dist_d;
  logic [15:0] az_q, az_d;
  logic [15:0] alt_acc_q, alt_acc_d;
  logic        alt_neg_q, alt_neg_d;
  logic [7:0]  run_sum_q, run_sum_d;
  logic [7:0]  rcv_sum_q, rcv_sum_d;
  logic [15:0] alt_q, alt_d;
  logic        test_q, test_d;
  logic        fix, home;
  logic [7:0]  run_sum_add;

  mtbp_decode u_decode (
    .rx_byte_i   (rx_byte_i),
    .char_class_o(cls)
  );

  assign run_sum_add = run_sum_q + rx_byte_i;

  always_comb begin
    field_d   = field_q;
    dist_d    = dist_q;
    az_d      = az_q;
    alt_acc_d = alt_acc_q;
    alt_neg_d = alt_neg_q;
    run_sum_d = run_sum_q;
    rcv_sum_d = rcv_sum_q;
    alt_d     = alt_q;
    test_d    = test_q;
    fix       = 1'b0;
    home      = 1'b0;
    case (cls)
      ChDist: begin
        field_d   = FsDist;
        dist_d    = '0;
        rcv_sum_d = '0;
        run_sum_d = rx_byte_i;
        alt_neg_d = 1'b0;
        test_d    = 1'b0;
      end
      ChAlt: begin
        field_d   = FsAlt;
        alt_acc_d = '0;
        run_sum_d = run_sum_add;
      end
      ChAz: begin
        field_d   = FsAz;
        az_d      = '0;
        run_sum_d = run_sum_add;
      end
      ChStar: field_d = FsSum;
      ChNewline: begin
        field_d = FsIdle;
        if (run_sum_q == rcv_sum_q) begin
          fix   = 1'b1;
          alt_d = alt_neg_q ? (~alt_acc_q + 16'd1) : alt_acc_q;
        end
      end
      ChHome: begin
        test_d = 1'b0;
        home   = 1'b1;
      end
      ChClear: test_d = 1'b0;
      ChNorth: begin
        az_d = AzNorth; dist_d = TestDist; alt_d = '0; test_d = 1'b1;
      end
      ChEast: begin
        az_d = AzEast; dist_d = TestDist; alt_d = TestAlt; test_d = 1'b1;
      end
      ChSouth: begin
        az_d = AzSouth; dist_d = '0; alt_d = TestAlt; test_d = 1'b1;
      end
      ChWest: begin
        az_d = AzWest; dist_d = TestDist; alt_d = '0; test_d = 1'b1;
      end
      default: begin
        // Any other byte feeds the selected field; idle drops it
        case (field_q)
          FsDist: begin
            dist_d    = times_ten_add16(dist_q, rx_byte_i);
            run_sum_d = run_sum_add;
          end
          FsAlt: begin
            run_sum_d = run_sum_add;
            if (rx_byte_i == CharMinus) alt_neg_d = 1'b1;
            else alt_acc_d = times_ten_add16(alt_acc_q, rx_byte_i);
          end
          FsAz: begin
            az_d      = times_ten_add16(az_q, rx_byte_i);
            run_sum_d = run_sum_add;
          end
          FsSum: rcv_sum_d = times_ten_add8(rcv_sum_q, rx_byte_i);
          default: ;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q   <= FsIdle;
      dist_q    <= '0;
      az_q      <= '0;
      alt_acc_q <= '0;
      alt_neg_q <= 1'b0;
      run_sum_q <= RunSumReset;
      rcv_sum_q <= RcvSumReset;
      alt_q     <= '0;
      test_q    <= 1'b0;
    end else if (en_i) begin
      field_q   <= field_d;
      dist_q    <= dist_d;
      az_q      <= az_d;
      alt_acc_q <= alt_acc_d;
      alt_neg_q <= alt_neg_d;
      run_sum_q <= run_sum_d;
      rcv_sum_q <= rcv_sum_d;
      alt_q     <= alt_d;
      test_q    <= test_d;
    end
  end

  assign result_o = '{distance: dist_d, azimuth: az_d, altitude: alt_d,
                      fix: fix, home: home, test: test_d};

endmodule

// ----- hdl/mfd_telemetry_byte_parser.sv -----
// Top level of the telemetry byte parser: input register, parser core, result register.
// Depends on mtbp_pkg and mtbp_core.

// One ASCII byte goes in per beat and one result beat comes out per byte, in order.
// The block takes a byte every cycle unless in_stall_o is high. An accepted byte waits in
// the input register until the output can take a result; then the parser update is
// captured into the result register. Distance and azimuth follow the digits live,
// altitude changes only on a newline with a matching checksum or on a compass test
// character, and fix_event and home_event are single-beat pulses. Stall on the output
// holds the result register and, once the input register is also full, stalls the input.
module mfd_telemetry_byte_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        distance_o,
  output logic [15:0]        azimuth_o,
  output logic signed [15:0] altitude_o,
  output logic               fix_event_o,
  output logic               home_event_o,
  output logic               test_mode_o
);
  import mtbp_pkg::*;

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       out_valid_q;
  result_t    res_q, res_core;
  logic       out_load, advance, in_load;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_load;
  assign in_stall_o = in_valid_q && !out_load;
  assign in_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      byte_q <= rx_byte_i;
    end
  end

  mtbp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .rx_byte_i(byte_q),
    .result_o (res_core)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Hold the result while stalled
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_core;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign distance_o   = res_q.distance;
  assign azimuth_o    = res_q.azimuth;
  assign altitude_o   = signed'(res_q.altitude);
  assign fix_event_o  = res_q.fix;
  assign home_event_o = res_q.home;
  assign test_mode_o  = res_q.test;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  a_event_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(fix_event_o && home_event_o))
    else $error("fix and home events in one beat");

  a_home_clears_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && home_event_o) |-> !test_mode_o)
    else $error("home event with test mode set");

  a_core_only_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

endmodule

// ----- tb/mfd_telemetry_byte_parser_tb.sv -----
// Self-checking testbench for mfd_telemetry_byte_parser: random input idle and output stall,
// framed telemetry traffic with correct and broken checksums, control and noise bytes.
// Depends on mtbp_pkg and the parser RTL.
`timescale 1ns / 100ps

module mfd_telemetry_byte_parser_tb;
  import mtbp_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 8;
  localparam int TargetBytes   = 750;

  typedef logic [7:0] char_seq_t[$];

  // Tracks the parser state and holds the per-byte results still due.
  class telemetry_scoreboard;
    logic [2:0]  field;
    logic [15:0] dist_acc;
    logic [15:0] az_acc;
    logic [15:0] alt_acc;
    logic [15:0] alt_held;
    logic        alt_neg;
    logic        test_on;
    logic [7:0]  run_sum;
    logic [7:0]  rcv_sum;
    result_t     expected_q[$];
    int          failures;

    function new();
      field    = FsIdle;
      dist_acc = '0;
      az_acc   = '0;
      alt_acc  = '0;
      alt_held = '0;
      alt_neg  = 1'b0;
      test_on  = 1'b0;
      run_sum  = RunSumReset;
      rcv_sum  = RcvSumReset;
      failures = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function logic [15:0] tenfold_add(logic [15:0] acc, logic [7:0] ch);
      logic [31:0] t;
      t = {16'd0, acc} * 32'd10 + {24'd0, ch} - {24'd0, AsciiZero};
      return t[15:0];
    endfunction

    function void load_compass(logic [15:0] az, logic [15:0] dist_val, logic [15:0] alt);
      az_acc   = az;
      dist_acc = dist_val;
      alt_held = alt;
      test_on  = 1'b1;
    endfunction

    function void note_byte(logic [7:0] ch);
      result_t     r;
      logic        fix;
      logic        home;
      logic [15:0] t;
      fix  = 1'b0;
      home = 1'b0;
      case (ch)
        CharD: begin
          field    = FsDist;
          dist_acc = '0;
          rcv_sum  = '0;
          run_sum  = CharD;
          alt_neg  = 1'b0;
          test_on  = 1'b0;
        end
        CharH: begin
          field   = FsAlt;
          alt_acc = '0;
          run_sum = run_sum + ch;
        end
        CharA: begin
          field   = FsAz;
          az_acc  = '0;
          run_sum = run_sum + ch;
        end
        CharStar: field = FsSum;
        CharNl: begin
          if (run_sum == rcv_sum) begin
            fix      = 1'b1;
            alt_held = alt_neg ? 16'd0 - alt_acc : alt_acc;
          end
          field = FsIdle;
        end
        CharX: begin
          test_on = 1'b0;
          home    = 1'b1;
        end
        CharHash, CharAt: test_on = 1'b0;
        CharN: load_compass(AzNorth, TestDist, 16'd0);
        CharE: load_compass(AzEast, TestDist, TestAlt);
        CharS: load_compass(AzSouth, 16'd0, TestAlt);
        CharW: load_compass(AzWest, TestDist, 16'd0);
        default: begin
          case (field)
            FsDist: begin
              dist_acc = tenfold_add(dist_acc, ch);
              run_sum  = run_sum + ch;
            end
            FsAlt: begin
              run_sum = run_sum + ch;
              if (ch == CharMinus) alt_neg = 1'b1;
              else alt_acc = tenfold_add(alt_acc, ch);
            end
            FsAz: begin
              az_acc  = tenfold_add(az_acc, ch);
              run_sum = run_sum + ch;
            end
            FsSum: begin
              t       = tenfold_add({8'd0, rcv_sum}, ch);
              rcv_sum = t[7:0];
            end
            default: ;
          endcase
        end
      endcase
      r.distance = dist_acc;
      r.azimuth  = az_acc;
      r.altitude = alt_held;
      r.fix      = fix;
      r.home     = home;
      r.test     = test_on;
      expected_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected beat: dist=%0d az=%0d alt=%0d fix=%0b home=%0b test=%0b",
                         got.distance, got.azimuth, $signed(got.altitude),
                         got.fix, got.home, got.test));
        return;
      end
      want = expected_q.pop_front();
      if (got.distance !== want.distance || got.azimuth !== want.azimuth ||
          got.altitude !== want.altitude || got.fix !== want.fix ||
          got.home !== want.home || got.test !== want.test)
        report($sformatf({"mismatch: exp dist=%0d az=%0d alt=%0d fix=%0b home=%0b test=%0b",
                          " | got dist=%0d az=%0d alt=%0d fix=%0b home=%0b test=%0b"},
                         want.distance, want.azimuth, $signed(want.altitude),
                         want.fix, want.home, want.test,
                         got.distance, got.azimuth, $signed(got.altitude),
                         got.fix, got.home, got.test));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic [7:0]         rx_byte = 8'd0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [15:0]        distance;
  logic [15:0]        azimuth;
  logic signed [15:0] altitude;
  logic               fix_event;
  logic               home_event;
  logic               test_mode;

  telemetry_scoreboard sb;
  int   bytes_sent;
  int   idle_cycles;
  int   stall_left;
  int   stall_calm;
  bit   sender_calm;
  logic [7:0] ctrl_chars[8] = '{CharX, CharN, CharE, CharS, CharW, CharHash, CharAt, CharNl};

  mfd_telemetry_byte_parser dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .rx_byte_i   (rx_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .distance_o  (distance),
    .azimuth_o   (azimuth),
    .altitude_o  (altitude),
    .fix_event_o (fix_event),
    .home_event_o(home_event),
    .test_mode_o (test_mode)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit is_control(logic [7:0] ch);
    return ch inside {CharD, CharH, CharA, CharStar, CharNl, CharX,
                      CharHash, CharAt, CharN, CharE, CharS, CharW};
  endfunction

  // Mostly digits; now and then a stray byte that wraps the accumulator.
  function automatic char_seq_t field_chars(bit alt);
    char_seq_t  f;
    int         len;
    logic [7:0] ch;
    f = {};
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 5);
    if (alt && $urandom_range(0, 2) == 0) f.push_back(CharMinus);
    repeat (len) begin
      if ($urandom_range(0, 9) != 0) begin
        ch = AsciiZero + 8'($urandom_range(0, 9));
      end else begin
        ch = 8'($urandom);
        while (is_control(ch)) ch = 8'($urandom);
      end
      f.push_back(ch);
    end
    return f;
  endfunction

  // Append '*', the decimal checksum (spoiled when bad), and newline.
  function automatic char_seq_t close_frame(char_seq_t body, bit good);
    char_seq_t  seq;
    logic [7:0] sum;
    int         v;
    string      digits;
    seq = body;
    sum = '0;
    foreach (body[i]) sum = sum + body[i];
    v = int'(sum) + 256 * $urandom_range(0, 2);
    if (!good) v += $urandom_range(1, 255);
    digits = $sformatf("%0d", v);
    if ($urandom_range(0, 4) == 0) digits = {"0", digits};
    seq.push_back(CharStar);
    for (int i = 0; i < digits.len(); i++) seq.push_back(digits[i]);
    seq.push_back(CharNl);
    return seq;
  endfunction

  function automatic char_seq_t make_frame(bit good);
    char_seq_t seq;
    seq = {CharD};
    seq = {seq, field_chars(1'b0)};
    seq.push_back(CharH);
    seq = {seq, field_chars(1'b1)};
    seq.push_back(CharA);
    seq = {seq, field_chars(1'b0)};
    seq = close_frame(seq, good);
    // Cut some broken frames short so the next one lands mid-field.
    if (!good && $urandom_range(0, 1) == 0)
      seq = seq[0:$urandom_range(0, seq.size() - 2)];
    return seq;
  endfunction

  task automatic send_byte(logic [7:0] ch);
    int gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_seq(char_seq_t seq);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Hold the input until every result due has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // Output stall: random bursts, with quiet stretches that start no new burst.
  always @(posedge clk) begin
    if (stall_calm > 0) stall_calm--;
    else if ($urandom_range(0, 299) == 0) stall_calm = $urandom_range(50, 200);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (stall_calm == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_byte(rx_byte);
      if (out_valid && !out_stall) begin
        got.distance = distance;
        got.azimuth  = azimuth;
        got.altitude = altitude;
        got.fix      = fix_event;
        got.home     = home_event;
        got.test     = test_mode;
        sb.check_result(got);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int r;
    sb = new();
    bytes_sent  = 0;
    idle_cycles = 0;
    stall_left  = 0;
    stall_calm  = 0;
    sender_calm = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte extremes in idle, a newline in the reset state, every control char,
    // then a frame with a minus in distance, negative altitude and a 0xFF in azimuth.
    send_seq({8'h00, 8'hFF, CharNl, CharX, CharN, CharE, CharS, CharW, CharHash, CharAt});
    send_seq(close_frame({CharD, 8'h39, CharMinus, CharH, CharMinus, 8'h37, CharA, 8'hFF},
                         1'b1));
    drain();

    while (bytes_sent < TargetBytes) begin
      r = $urandom_range(0, 99);
      if (r < 65) send_seq(make_frame(1'b1));
      else if (r < 80) send_seq(make_frame(1'b0));
      else if (r < 90) send_byte(ctrl_chars[$urandom_range(0, 7)]);
      else repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
      if ($urandom_range(0, 59) == 0) drain();
    end

    drain();
    repeat (DrainCycles) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
